[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the tokenizer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define ZRLT_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define ZRLT_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

[hw/rtl/zrlt_pkg.sv]
// ----------------------------------------------------------------------------
// zrlt_pkg
// Types, token codes and the zigzag scan table of the run-length tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package zrlt_pkg;

  localparam int unsigned BLOCK_LEN  = 64;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned COEF_W     = 16;

  localparam logic [1:0] KIND_DC  = 2'd0;
  localparam logic [1:0] KIND_AC  = 2'd1;
  localparam logic [1:0] KIND_ZRL = 2'd2;
  localparam logic [1:0] KIND_EOB = 2'd3;

  localparam logic [POS_W-1:0] POS_FIRST = 6'd0;
  localparam logic [POS_W-1:0] POS_LAST  = 6'd63;
  localparam logic [POS_W-1:0] AC_FIRST  = 6'd1;

  typedef struct packed {
    logic signed [15:0] coef;
    logic               new_component;
  } item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         zero_run;
    logic signed [15:0] value;
    logic               last;
  } token_t;

  // Token offered by the scanner to the output register.
  typedef struct packed {
    logic   valid;
    token_t tok;
  } emit_t;

  // Raster address of each zigzag position.
  localparam logic [POS_W-1:0] ZZ_ORDER [BLOCK_LEN] = '{
     6'd0,  6'd1,  6'd8, 6'd16,  6'd9,  6'd2,  6'd3, 6'd10,
    6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11,  6'd4,  6'd5,
    6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
    6'd27, 6'd20, 6'd13,  6'd6,  6'd7, 6'd14, 6'd21, 6'd28,
    6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
    6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
    6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
    6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
  };

endpackage

`default_nettype wire

[hw/rtl/zigzag_run_length_tokenizer_unit.sv]
// ----------------------------------------------------------------------------
// zigzag_run_length_tokenizer_unit
// Turns 8x8 blocks of quantized coefficients into DC and run-length tokens.
// ----------------------------------------------------------------------------
// Usage:
// Coefficients arrive on the item channel, 64 per block in raster order.
// Setting new_component on the first coefficient of a block clears the DC
// predictor before the difference is formed; on other coefficients it is
// ignored. Tokens leave on the token channel through one output register.
// The first coefficient yields the DC token in the cycle after its transfer.
// Coefficients 2 to 63 yield nothing and are taken one per cycle. The 64th
// coefficient starts the zigzag scan: the scanner reads each of the 63 AC
// coefficients from the store and then evaluates it; a nonzero value gets a
// sixteen-zero token per full run of sixteen zeros before it, then its own
// token. The scan ends with the end-of-block token. The item channel stalls
// for the whole scan, and on a first coefficient while an unaccepted token
// still sits in the output register. When the receiver stalls, the output
// register holds its token and the scanner waits to emit its next token.
// Reset empties the output register, returns the scanner to idle, zeroes
// the DC predictor and the coefficient position.
// ----------------------------------------------------------------------------
`default_nettype none

module zigzag_run_length_tokenizer_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_stall,
  input  wire zrlt_pkg::item_t item,
  output logic                 token_valid,
  input  wire logic            token_stall,
  output zrlt_pkg::token_t     token
);

  logic [5:0]        load_count;
  logic [15:0]       dc_predictor;
  logic              accept;
  logic              first_pos;
  logic              out_free;
  logic [15:0]       dc_base;
  logic              scan_busy;
  logic              rd_en;
  logic [5:0]        rd_addr;
  logic [15:0]       rdata;
  zrlt_pkg::emit_t   emit;
  zrlt_pkg::token_t  dc_tok;

  assign first_pos  = (load_count == zrlt_pkg::POS_FIRST);
  assign out_free   = !token_valid || !token_stall;
  // A first coefficient writes the output register, so it needs room there.
  assign item_stall = scan_busy || (first_pos && !out_free);
  assign accept     = item_valid && !item_stall;

  // DC difference against the previous block, wrapping modulo 2^16.
  assign dc_base         = item.new_component ? 16'd0 : dc_predictor;
  assign dc_tok.kind     = zrlt_pkg::KIND_DC;
  assign dc_tok.zero_run = 4'd0;
  assign dc_tok.value    = $signed(item.coef - dc_base);
  assign dc_tok.last     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count   <= '0;
      dc_predictor <= '0;
    end else if (accept) begin
      load_count <= load_count + 6'd1;
      if (first_pos) begin
        dc_predictor <= item.coef;
      end
    end
  end

  zrlt_ram #(
    .WIDTH (zrlt_pkg::COEF_W),
    .DEPTH (zrlt_pkg::BLOCK_LEN)
  ) u_store (
    .clk   (clk),
    .we    (accept),
    .waddr (load_count),
    .wdata (item.coef),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // The scan starts once the last coefficient of the block is in the store.
  zrlt_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && (load_count == zrlt_pkg::POS_LAST)),
    .out_free (out_free),
    .rdata    (rdata),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .emit     (emit),
    .busy     (scan_busy)
  );

  // Output register. The scanner and a first coefficient never load it in
  // the same cycle, since items stall while the scan runs.
  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
    end else if (emit.valid || (accept && first_pos)) begin
      token_valid <= 1'b1;
    end else if (!token_stall) begin
      token_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      token <= emit.tok;
    end else if (accept && first_pos) begin
      token <= dc_tok;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/zrlt_ram.sv]
// ----------------------------------------------------------------------------
// zrlt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module zrlt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/zrlt_scan.sv]
// ----------------------------------------------------------------------------
// zrlt_scan
// Sequencer that walks the stored block in zigzag order and forms AC, zero-run and end-of-block tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module zrlt_scan (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              out_free,
  input  wire logic [15:0]       rdata,
  output logic                   rd_en,
  output logic [5:0]             rd_addr,
  output zrlt_pkg::emit_t        emit,
  output logic                   busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_EOB  = 2'd3;

  logic [1:0] state, state_next;
  logic [5:0] idx, idx_next;
  logic [5:0] run, run_next;
  logic       is_zero;
  logic       long_run;

  assign is_zero  = (rdata == 16'd0);
  assign long_run = (run[5:4] != 2'd0);
  assign busy     = (state != S_IDLE);
  assign rd_en    = (state == S_READ);
  assign rd_addr  = zrlt_pkg::ZZ_ORDER[idx];

  always_comb begin
    state_next = state;
    idx_next   = idx;
    run_next   = run;
    emit       = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_READ;
          idx_next   = zrlt_pkg::AC_FIRST;
          run_next   = '0;
        end
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (is_zero) begin
          run_next   = run + 6'd1;
          state_next = (idx == zrlt_pkg::POS_LAST) ? S_EOB : S_READ;
          idx_next   = idx + 6'd1;
        end else if (out_free) begin
          emit.valid = 1'b1;
          if (long_run) begin
            // A full run of sixteen zeros goes out before the value.
            emit.tok.kind     = zrlt_pkg::KIND_ZRL;
            emit.tok.zero_run = 4'd15;
            run_next          = run - 6'd16;
          end else begin
            emit.tok.kind     = zrlt_pkg::KIND_AC;
            emit.tok.zero_run = run[3:0];
            emit.tok.value    = $signed(rdata);
            run_next          = '0;
            state_next        = (idx == zrlt_pkg::POS_LAST) ? S_EOB : S_READ;
            idx_next          = idx + 6'd1;
          end
        end
      end
      S_EOB: begin
        if (out_free) begin
          emit.valid     = 1'b1;
          emit.tok.kind  = zrlt_pkg::KIND_EOB;
          emit.tok.last  = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      run   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      run   <= run_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/zrlt_checker.sv]
// ----------------------------------------------------------------------------
// zrlt_checker
// Port-level checks on the token stream of the run-length tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module zrlt_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             token_valid,
  input wire logic             token_stall,
  input wire zrlt_pkg::token_t token
);

  logic tok_dc, tok_ac, tok_zrl, tok_eob;
  logic held;
  logic dc_ok, ac_ok, zrl_ok, eob_ok;

  assign tok_dc  = token_valid && (token.kind == zrlt_pkg::KIND_DC);
  assign tok_ac  = token_valid && (token.kind == zrlt_pkg::KIND_AC);
  assign tok_zrl = token_valid && (token.kind == zrlt_pkg::KIND_ZRL);
  assign tok_eob = token_valid && (token.kind == zrlt_pkg::KIND_EOB);
  assign held    = token_valid && token_stall;

  // Expected shape of each token kind.
  assign dc_ok  = token.last && (token.zero_run == 4'd0);
  assign ac_ok  = !token.last && (token.value != 16'sd0);
  assign zrl_ok = !token.last && (token.zero_run == 4'd15) && (token.value == 16'sd0);
  assign eob_ok = token.last && (token.zero_run == 4'd0) && (token.value == 16'sd0);

  `ZRLT_ASSERT_NEXT(a_token_hold, held, token_valid && $stable(token), "stalled token changed")
  `ZRLT_ASSERT_NOW(a_dc_shape, tok_dc, dc_ok, "malformed DC token")
  `ZRLT_ASSERT_NOW(a_ac_shape, tok_ac, ac_ok, "malformed AC token")
  `ZRLT_ASSERT_NOW(a_zrl_shape, tok_zrl, zrl_ok, "malformed zero-run token")
  `ZRLT_ASSERT_NOW(a_eob_shape, tok_eob, eob_ok, "malformed end-of-block token")

endmodule

bind zigzag_run_length_tokenizer_unit zrlt_checker u_zrlt_checker (.*);

`default_nettype wire
